[sv/hybrid_array_sorter_macros.svh]
// assertion helpers used by the top sorter module
`ifndef HYBRID_ARRAY_SORTER_MACROS_SVH
`define HYBRID_ARRAY_SORTER_MACROS_SVH

// property that must hold at every clock edge outside reset
`define HAS_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// implication checked in the same cycle, outside reset
`define HAS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[sv/has_pkg.sv]
`timescale 1ns / 1ps

package has_pkg;

    // defaults for the top level parameters
    localparam int MAX_LEN_DEF    = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // width of the value fields on the channels
    localparam int FIELD_W = 32;

    // operation applied to every cell of the chain in the same cycle
    typedef struct packed {
        logic insert;
        logic shift;
    } cell_op_t;

    // sequencer states
    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } has_state_t;

endpackage

[sv/has_if.sv]
`timescale 1ns / 1ps

// input channel: one list element per transaction
interface has_item_if import has_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] value;
    logic                      is_last;

    modport source (output valid, value, is_last, input ready);
    modport sink (input valid, value, is_last, output ready);
endinterface

// output channel: one sorted element per transaction
interface has_result_if import has_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] sorted_value;
    logic                      last_out;
    logic                      overflow;

    modport source (output valid, sorted_value, last_out, overflow, input ready);
    modport sink (input valid, sorted_value, last_out, overflow, output ready);
endinterface

[sv/hybrid_array_sorter.sv]
`timescale 1ns / 1ps
// Ascending sorter for lists of signed integers.
// items: one list element per transaction (value, is_last). While a list is
//   being filled an element is taken in every cycle; each element is placed
//   at once into a chain of MAX_LEN compare-and-shift cells kept in order.
// results: after the element with is_last is taken, the stored list leaves
//   in ascending order from the head cell, one transaction per cycle while results.ready is high;
//   last_out marks the final one, overflow is set on all of them when
//   elements beyond MAX_LEN were dropped (the is_last element is dropped
//   too when the chain is full, but still ends the list).
// Latency: the first result is valid the cycle after the is_last transaction.
// Throughput: one element per cycle while filling; while the results drain,
//   items.ready is low, so no new list is taken; the next list starts the cycle
//   after the last result is taken.
// Stall: a held results.ready freezes the chain; nothing is lost.
// Reset: all cells empty, count and drop flag cleared, items.ready high.
// Values are kept at DATA_WIDTH bits (zero extended if wider); sign extended to 32 bits if narrower.

module hybrid_array_sorter import has_pkg::*; #(
    parameter int MAX_LEN    = MAX_LEN_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    has_item_if.sink     items,
    has_result_if.source results
);

`include "hybrid_array_sorter_macros.svh"

    cell_op_t                     op;
    logic signed [DATA_WIDTH-1:0] in_data;
    logic signed [DATA_WIDTH-1:0] cell_value [MAX_LEN];
    logic [MAX_LEN-1:0]           cell_valid;
    logic [MAX_LEN-1:0]           cell_gt;

    // bring the input field to the stored width
    generate
        if (DATA_WIDTH >= FIELD_W)
        begin : g_in_wide
            assign in_data = DATA_WIDTH'($unsigned(items.value));
        end
        else
        begin : g_in_narrow
            assign in_data = items.value[DATA_WIDTH-1:0];
        end
    endgenerate

    // sequencer
    has_ctrl #(
        .MAX_LEN (MAX_LEN)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (items.valid),
        .in_last   (items.is_last),
        .in_ready  (items.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .last_out  (results.last_out),
        .overflow  (results.overflow),
        .op        (op)
    );

    // chain of cells, head at index 0
    generate
        for (genvar i = 0; i < MAX_LEN; i++)
        begin : g_cell
            logic signed [DATA_WIDTH-1:0] prev_value;
            logic                         prev_valid;
            logic                         prev_gt;
            logic signed [DATA_WIDTH-1:0] next_value;
            logic                         next_valid;

            if (i == 0)
            begin : g_head
                assign prev_value = '0;
                assign prev_valid = 1'b0;
                assign prev_gt    = 1'b0;
            end
            else
            begin : g_body
                assign prev_value = cell_value[i-1];
                assign prev_valid = cell_valid[i-1];
                assign prev_gt    = cell_gt[i-1];
            end

            if (i == MAX_LEN - 1)
            begin : g_tail
                assign next_value = '0;
                assign next_valid = 1'b0;
            end
            else
            begin : g_inner
                assign next_value = cell_value[i+1];
                assign next_valid = cell_valid[i+1];
            end

            has_cell #(
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .op         (op),
                .new_value  (in_data),
                .prev_value (prev_value),
                .prev_valid (prev_valid),
                .prev_gt    (prev_gt),
                .next_value (next_value),
                .next_valid (next_valid),
                .value      (cell_value[i]),
                .valid      (cell_valid[i]),
                .gt         (cell_gt[i])
            );
        end
    endgenerate

    // head cell drives the result payload
    generate
        if (DATA_WIDTH >= FIELD_W)
        begin : g_out_wide
            assign results.sorted_value = cell_value[0][FIELD_W-1:0];
        end
        else
        begin : g_out_narrow
            assign results.sorted_value = FIELD_W'(cell_value[0]);
        end
    endgenerate

    // occupied cells always form a run from the head
    `HAS_ASSERT_ALWAYS(a_valid_run, (cell_valid & (cell_valid + MAX_LEN'(1))) == '0, "gap in cell chain")
    // a result is only shown from an occupied head cell
    `HAS_ASSERT_IMPLY(a_head_valid, results.valid, cell_valid[0], "result from empty head cell")
    // the final result leaves exactly one element in the chain
    `HAS_ASSERT_IMPLY(a_last_single, results.valid && results.last_out, !cell_valid[1], "last_out with elements left")
    // filling and draining never overlap
    `HAS_ASSERT_IMPLY(a_no_overlap, items.ready, !results.valid, "fill and drain at once")

endmodule

[sv/has_cell.sv]
`timescale 1ns / 1ps

module has_cell import has_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cell_op_t                     op,
    input  logic signed [DATA_WIDTH-1:0] new_value,
    input  logic signed [DATA_WIDTH-1:0] prev_value,
    input  logic                         prev_valid,
    input  logic                         prev_gt,
    input  logic signed [DATA_WIDTH-1:0] next_value,
    input  logic                         next_valid,
    output logic signed [DATA_WIDTH-1:0] value,
    output logic                         valid,
    output logic                         gt
);

    logic signed [DATA_WIDTH-1:0] value_reg;
    logic signed [DATA_WIDTH-1:0] value_next;
    logic                         valid_reg;
    logic                         valid_next;

    // empty cells count as larger than anything
    assign gt = !valid_reg || (value_reg > new_value);

    // insert: take the left neighbor, or the new value at the insertion point
    // shift: take the right neighbor toward the output
    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (op.shift)
        begin
            value_next = next_value;
            valid_next = next_valid;
        end
        else if (op.insert)
        begin
            if (prev_gt)
            begin
                value_next = prev_value;
                valid_next = prev_valid;
            end
            else if (gt)
            begin
                value_next = new_value;
                valid_next = 1'b1;
            end
        end
    end

    // occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // stored element
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

[sv/has_ctrl.sv]
`timescale 1ns / 1ps

module has_ctrl import has_pkg::*; #(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_last,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output logic     last_out,
    output logic     overflow,
    output cell_op_t op
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);

    has_state_t       state_reg;
    has_state_t       state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             dropped_reg;
    logic             dropped_next;
    logic             full;

    assign full = (count_reg == CNT_W'(MAX_LEN));

    // state, element count and drop flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_FILL;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
        end
    end

    // fill takes one element per cycle, drain gives one result per cycle while out_ready is high
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        op           = '0;
        unique case (state_reg)
            ST_FILL:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        op.insert  = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (in_last)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    op.shift   = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                    if (count_reg == CNT_W'(1))
                    begin
                        state_next   = ST_FILL;
                        dropped_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    assign last_out = (count_reg == CNT_W'(1));
    assign overflow = dropped_reg;

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import has_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 20;

    // one sorted element as it leaves the block
    typedef struct packed {
        logic signed [FIELD_W-1:0] value;
        logic                      last;
        logic                      ovf;
    } sorted_word_t;

    // directed stimulus row, with a typed-in result for one-element lists
    typedef struct packed {
        logic signed [FIELD_W-1:0] value;
        logic                      last;
        logic                      typed;
        logic signed [FIELD_W-1:0] want;
        logic                      want_last;
        logic                      want_ovf;
    } list_row_t;

    localparam int DIRECTED_ROWS = 18;

    logic clk;
    logic rst_n;

    has_item_if   items_ch ();
    has_result_if results_ch ();

    hybrid_array_sorter i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_ch),
        .results (results_ch)
    );

    // sorted list under construction and drop flag of the current list
    logic signed [FIELD_W-1:0] held_values[$];
    logic                      dropped;

    // sorted elements still to come out of the block
    sorted_word_t due_q[$];

    int error_count;
    int items_sent;
    int hold_request;
    int hold_left;
    int stall_left;
    bit calm;
    sorted_word_t want_word;

    list_row_t directed_rows[DIRECTED_ROWS] = '{
        // one-element lists at the extremes
        '{32'sh8000_0000, 1'b1, 1'b1, 32'sh8000_0000, 1'b1, 1'b0},
        '{32'sh7FFF_FFFF, 1'b1, 1'b1, 32'sh7FFF_FFFF, 1'b1, 1'b0},
        '{32'sh0000_0000, 1'b1, 1'b1, 32'sh0000_0000, 1'b1, 1'b0},
        '{-32'sd1,        1'b1, 1'b1, -32'sd1,        1'b1, 1'b0},
        // mixed signs with both extremes inside one list
        '{32'sd5,         1'b0, 1'b0, '0, 1'b0, 1'b0},
        '{-32'sd3,        1'b0, 1'b0, '0, 1'b0, 1'b0},
        '{32'sh7FFF_FFFF, 1'b0, 1'b0, '0, 1'b0, 1'b0},
        '{32'sh8000_0000, 1'b0, 1'b0, '0, 1'b0, 1'b0},
        '{32'sd0,         1'b1, 1'b0, '0, 1'b0, 1'b0},
        // equal values side by side
        '{32'sd7,         1'b0, 1'b0, '0, 1'b0, 1'b0},
        '{32'sd7,         1'b0, 1'b0, '0, 1'b0, 1'b0},
        '{-32'sd7,        1'b0, 1'b0, '0, 1'b0, 1'b0},
        '{32'sd7,         1'b1, 1'b0, '0, 1'b0, 1'b0},
        // descending input
        '{32'sh4000_0000, 1'b0, 1'b0, '0, 1'b0, 1'b0},
        '{32'sd1,         1'b0, 1'b0, '0, 1'b0, 1'b0},
        '{-32'sh4000_0000, 1'b1, 1'b0, '0, 1'b0, 1'b0},
        // ascending input
        '{-32'sd5,        1'b0, 1'b0, '0, 1'b0, 1'b0},
        '{32'sd5,         1'b1, 1'b0, '0, 1'b0, 1'b0}
    };

    // clock
    always #(CLK_PERIOD / 2) clk = ~clk;

    // report one mismatch and count it
    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    // insertion into the ascending list; emits the list on the last element
    task automatic sort_element(input logic signed [FIELD_W-1:0] v, input logic l,
                                output sorted_word_t outs[$]);
        int pos;
        outs = {};
        if (held_values.size() < MAX_LEN_DEF)
        begin
            pos = held_values.size();
            while (pos > 0 && held_values[pos-1] > v)
                pos--;
            held_values.insert(pos, v);
        end
        else
            dropped = 1'b1;
        if (l)
        begin
            foreach (held_values[k])
                outs.push_back('{held_values[k], (k == held_values.size() - 1), dropped});
            held_values = {};
            dropped     = 1'b0;
        end
    endtask

    // random element: full range, a narrow band for repeats, or an extreme
    function automatic logic signed [FIELD_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return int'($urandom_range(0, 16)) - 8;
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7FFF_FFFF;
                    2: return 32'sh0000_0000;
                    default: return -32'sd1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // offer one element and wait for its transaction
    task automatic push_item(input logic signed [FIELD_W-1:0] v, input logic l,
                             input bit typed, input sorted_word_t typed_word);
        sorted_word_t outs[$];
        items_ch.valid   <= 1'b1;
        items_ch.value   <= v;
        items_ch.is_last <= l;
        @(posedge clk);
        while (items_ch.ready !== 1'b1)
            @(posedge clk);
        items_sent++;
        sort_element(v, l, outs);
        if (typed)
            due_q.push_back(typed_word);
        else
            foreach (outs[k])
                due_q.push_back(outs[k]);
    endtask

    // random sender idle burst ahead of an element
    task automatic maybe_gap();
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            items_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    // one list of random elements, the final one flagged
    task automatic send_list(input int len);
        for (int i = 0; i < len; i++)
        begin
            maybe_gap();
            push_item(pick_value(), (i == len - 1), 1'b0, '0);
        end
    endtask

    // result checker and receiver backpressure
    always @(posedge clk)
    begin
        if (rst_n && results_ch.valid === 1'b1 && results_ch.ready === 1'b1)
        begin
            if (due_q.size() == 0)
                flag_error($sformatf("unexpected result transaction, value %0d",
                                     results_ch.sorted_value));
            else
            begin
                want_word = due_q.pop_front();
                if (results_ch.sorted_value !== want_word.value)
                    flag_error($sformatf("sorted_value %0d, expected %0d",
                                         results_ch.sorted_value, want_word.value));
                if (results_ch.last_out !== want_word.last)
                    flag_error($sformatf("last_out %b, expected %b",
                                         results_ch.last_out, want_word.last));
                if (results_ch.overflow !== want_word.ovf)
                    flag_error($sformatf("overflow %b, expected %b",
                                         results_ch.overflow, want_word.ovf));
            end
        end

        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            results_ch.ready <= 1'b0;
            hold_left--;
        end
        else if (stall_left > 0 && !calm)
        begin
            results_ch.ready <= 1'b0;
            stall_left--;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            results_ch.ready <= 1'b0;
            stall_left = $urandom_range(1, 17) - 1;
        end
        else
            results_ch.ready <= 1'b1;
    end

    // watchdog on cycles without any transaction
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((items_ch.valid === 1'b1 && items_ch.ready === 1'b1) ||
                (results_ch.valid === 1'b1 && results_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // stimulus sequence
    initial
    begin : stimulus
        sorted_word_t row_word;
        clk              = 1'b0;
        rst_n            = 1'b0;
        items_ch.valid   = 1'b0;
        items_ch.value   = '0;
        items_ch.is_last = 1'b0;
        results_ch.ready = 1'b0;
        dropped          = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed lists
        foreach (directed_rows[i])
        begin
            row_word = '{directed_rows[i].want, directed_rows[i].want_last,
                         directed_rows[i].want_ovf};
            maybe_gap();
            push_item(directed_rows[i].value, directed_rows[i].last,
                      directed_rows[i].typed, row_word);
        end

        // short random lists
        while (items_sent < DIRECTED_ROWS + 4)
            send_list($urandom_range(1, 10));

        // long receiver hold while the sender keeps offering
        hold_request = HOLD_CYCLES;
        send_list(6);
        send_list(3);

        // sender pause until the block has drained
        items_ch.valid <= 1'b0;
        while (due_q.size() != 0)
            @(posedge clk);

        // exactly full list, then one whose final element is dropped
        send_list(MAX_LEN_DEF);
        send_list(MAX_LEN_DEF + 1);

        // last stretch with no idling on either side
        calm = 1'b1;
        send_list(1);
        send_list(3);
        send_list(4);

        items_ch.valid <= 1'b0;
        while (due_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[hybrid_array_sorter.f]
+incdir+sv
sv/has_pkg.sv
sv/has_if.sv
sv/has_cell.sv
sv/has_ctrl.sv
sv/hybrid_array_sorter.sv
bench/tb_top.sv
